[design/tbse_pkg.sv]
// tbse_pkg: types, byte codes and sizes shared by the temperature bucket
// stream encoder. No dependencies.
package tbse_pkg;

	// input opcodes
	localparam logic OP_BEGIN  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// stream byte codes
	localparam logic [7:0] BYTE_HDR0 = 8'hC1;
	localparam logic [7:0] BYTE_HDR1 = 8'h01;
	localparam logic [7:0] BYTE_TS   = 8'hF0;
	localparam logic [7:0] BYTE_EXC  = 8'hE5;
	localparam logic [7:0] BYTE_END  = 8'hEE;

	// configuration register indexes
	localparam logic [1:0] REG_EXC_LOW  = 2'd0;
	localparam logic [1:0] REG_EXC_HIGH = 2'd1;
	localparam logic [1:0] REG_BASE     = 2'd2;

	localparam int BUCKET_WIDTH = 50;
	localparam int NIB_W        = 4;
	localparam int TEMP_W       = 15;
	localparam int JOB_BYTES    = 7;
	localparam int JOB_CNT_W    = 3;
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_W      = 2;
	localparam int Q_CNT_W      = 3;

	localparam logic [TEMP_W-1:0] RST_EXC_LOW  = 15'd2300;
	localparam logic [TEMP_W-1:0] RST_EXC_HIGH = 15'd2450;
	localparam logic [TEMP_W-1:0] RST_BASE     = 15'd2200;

	typedef struct packed {
		logic signed [TEMP_W-1:0] exc_low;
		logic signed [TEMP_W-1:0] exc_high;
		logic signed [TEMP_W-1:0] base;
	} cfg_t;

	// bytes caused by one item, in emit order
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [JOB_CNT_W-1:0]      count;
		logic                      ends;
	} job_t;

endpackage

[design/tbse_item_if.sv]
// tbse_item_if: input item channel (valid/ready plus sample payload)
// depends on nothing
interface tbse_item_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [15:0]        sample_count;
	logic [31:0]        time_ms;
	logic signed [14:0] temp_centi;

	modport source (output valid, opcode, sample_count, time_ms, temp_centi, input ready);
	modport sink (input valid, opcode, sample_count, time_ms, temp_centi, output ready);
endinterface

[design/tbse_result_if.sv]
// tbse_result_if: output byte channel (valid/ready plus byte and flags)
// depends on nothing
interface tbse_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_in_run;
	logic       stream_end;

	modport source (output valid, out_byte, last_in_run, stream_end, input ready);
	modport sink (input valid, out_byte, last_in_run, stream_end, output ready);
endinterface

[design/tbse_cfg_if.sv]
// tbse_cfg_if: configuration write channel (valid/ready, index, data)
// depends on nothing
interface tbse_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [14:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/tbse_front.sv]
// tbse_front: accepts items, keeps the stream state and builds the list of
// bytes each item causes. Depends on tbse_pkg and tbse_item_if.
module tbse_front import tbse_pkg::*; #(
	parameter int NUM_BUCKETS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	tbse_item_if.sink   item,
	input  cfg_t        cfg_regs,
	input  logic        q_full,
	output logic        q_push,
	output job_t        q_job
);

	logic                active_q, active_d;
	logic [15:0]         left_q, left_d;
	logic                seen_q, seen_d;
	logic                prev_exc_q, prev_exc_d;
	logic [NIB_W-1:0]    nib_q, nib_d;
	logic                pend_q, pend_d;
	logic                accept;
	logic                exc;
	logic signed [15:0]  diff;
	logic [NIB_W-1:0]    bucket;
	job_t                job_d;
	logic [JOB_CNT_W-1:0] n;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;

	// excursion test and bucket index
	always_comb begin
		exc  = (item.temp_centi < cfg_regs.exc_low) || (item.temp_centi > cfg_regs.exc_high);
		diff = {item.temp_centi[TEMP_W-1], item.temp_centi}
			- {cfg_regs.base[TEMP_W-1], cfg_regs.base};
		bucket = '0;
		if (!diff[15]) begin
			for (int k = 1; k < NUM_BUCKETS; k++) begin
				if (diff[14:0] >= 15'(k * BUCKET_WIDTH))
					bucket = NIB_W'(k);
			end
		end
	end

	// byte list and next state for the offered item
	always_comb begin
		active_d   = active_q;
		left_d     = left_q;
		seen_d     = seen_q;
		prev_exc_d = prev_exc_q;
		nib_d      = nib_q;
		pend_d     = pend_q;
		job_d      = '0;
		n          = '0;
		if (item.opcode == OP_BEGIN) begin
			active_d   = 1'b0;
			left_d     = '0;
			seen_d     = 1'b0;
			prev_exc_d = 1'b0;
			nib_d      = '0;
			pend_d     = 1'b0;
			job_d.bytes[n] = BYTE_HDR0;               n = n + 1'b1;
			job_d.bytes[n] = BYTE_HDR1;               n = n + 1'b1;
			job_d.bytes[n] = item.sample_count[7:0];  n = n + 1'b1;
			job_d.bytes[n] = item.sample_count[15:8]; n = n + 1'b1;
			job_d.bytes[n] = 8'(NUM_BUCKETS);         n = n + 1'b1;
			if (item.sample_count == '0) begin
				job_d.bytes[n] = BYTE_END;
				n = n + 1'b1;
				job_d.ends = 1'b1;
			end else begin
				active_d = 1'b1;
				left_d   = item.sample_count;
			end
		end else if (active_q) begin
			if (!seen_q) begin
				seen_d     = 1'b1;
				prev_exc_d = exc;
				job_d.bytes[n] = BYTE_TS;             n = n + 1'b1;
				job_d.bytes[n] = item.time_ms[7:0];   n = n + 1'b1;
				job_d.bytes[n] = item.time_ms[15:8];  n = n + 1'b1;
				job_d.bytes[n] = item.time_ms[23:16]; n = n + 1'b1;
				job_d.bytes[n] = item.time_ms[31:24]; n = n + 1'b1;
			end else if (exc != prev_exc_q) begin
				if (pend_d) begin
					job_d.bytes[n] = {nib_d, 4'h0};
					n = n + 1'b1;
					nib_d  = '0;
					pend_d = 1'b0;
				end
				job_d.bytes[n] = BYTE_EXC;
				n = n + 1'b1;
				prev_exc_d = exc;
			end
			// pack two buckets per byte, high nibble first
			if (!pend_d) begin
				nib_d  = bucket;
				pend_d = 1'b1;
			end else begin
				job_d.bytes[n] = {nib_d, bucket};
				n = n + 1'b1;
				nib_d  = '0;
				pend_d = 1'b0;
			end
			left_d = left_q - 16'd1;
			// stream closes on the final sample
			if (left_d == '0) begin
				if (pend_d) begin
					job_d.bytes[n] = {nib_d, 4'h0};
					n = n + 1'b1;
					nib_d  = '0;
					pend_d = 1'b0;
				end
				job_d.bytes[n] = BYTE_END;
				n = n + 1'b1;
				job_d.ends = 1'b1;
				active_d   = 1'b0;
				seen_d     = 1'b0;
				prev_exc_d = 1'b0;
			end
		end
		job_d.count = n;
	end

	assign q_push = accept && (n != '0);
	assign q_job  = job_d;

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			left_q     <= '0;
			seen_q     <= 1'b0;
			prev_exc_q <= 1'b0;
			nib_q      <= '0;
			pend_q     <= 1'b0;
		end else if (accept) begin
			active_q   <= active_d;
			left_q     <= left_d;
			seen_q     <= seen_d;
			prev_exc_q <= prev_exc_d;
			nib_q      <= nib_d;
			pend_q     <= pend_d;
		end
	end

endmodule

[design/tbse_fifo.sv]
// tbse_fifo: short queue of byte lists between front and back
// depends on tbse_pkg
module tbse_fifo import tbse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/tbse_back.sv]
// tbse_back: sends queued byte lists one beat per cycle while result is
// ready, through an output register. Needs tbse_pkg and tbse_result_if.
module tbse_back import tbse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          q_job,
	input  logic          q_empty,
	output logic          q_pop,
	tbse_result_if.source result
);

	job_t                 cur_q;
	logic                 busy_q;
	logic [JOB_CNT_W-1:0] idx_q;
	logic                 out_valid_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic                 end_q;
	logic                 emit;
	logic                 is_last;

	assign emit    = busy_q && (!out_valid_q || result.ready);
	assign is_last = (idx_q == cur_q.count - 1'b1);
	assign q_pop   = !q_empty && (!busy_q || (emit && is_last));

	assign result.valid       = out_valid_q;
	assign result.out_byte    = byte_q;
	assign result.last_in_run = last_q;
	assign result.stream_end  = end_q;

	// current byte list
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_job;
	end

	// walk through the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (emit) begin
			if (is_last)
				busy_q <= 1'b0;
			idx_q <= idx_q + 1'b1;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= cur_q.bytes[idx_q];
			last_q <= is_last;
			end_q  <= is_last && cur_q.ends;
		end
	end

endmodule

[design/temperature_bucket_stream_encoder_unit.sv]
// temperature_bucket_stream_encoder_unit: top level with configuration
// registers, front, queue and back. Depends on tbse_pkg, the channel
// interfaces, tbse_front, tbse_fifo and tbse_back.
//
//  channel  role  payload
//  item     sink  opcode, sample_count, time_ms, temp_centi
//  result   src   out_byte, last_in_run, stream_end
//  cfg      sink  index, data (always ready)
//
// An item is taken while the four-entry queue has room; the back sends one
// beat per cycle while result is ready, with no gap between items. An item
// causes up to 7 bytes. A sample inside a stream causes 0 or 1 bytes unless
// it is the first one, changes the excursion state or closes the stream.
// With the back idle, an accepted item passes the queue entry, the current
// list register and the output register before its first beat shows.
// arst_n clears the stream state, the queue and the output register and
// loads the thresholds and the bucket base with their defaults.
// A stalled result holds its beat; the queue then fills and item.ready drops.
module temperature_bucket_stream_encoder_unit import tbse_pkg::*; #(
	parameter int NUM_BUCKETS = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	tbse_item_if.sink     item,
	tbse_result_if.source result,
	tbse_cfg_if.sink      cfg
);

	cfg_t cfg_q;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t pop_job;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exc_low  <= RST_EXC_LOW;
			cfg_q.exc_high <= RST_EXC_HIGH;
			cfg_q.base     <= RST_BASE;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_EXC_LOW:  cfg_q.exc_low  <= cfg.data;
				REG_EXC_HIGH: cfg_q.exc_high <= cfg.data;
				REG_BASE:     cfg_q.base     <= cfg.data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	tbse_front #(
		.NUM_BUCKETS (NUM_BUCKETS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_regs (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	tbse_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	tbse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_job   (pop_job),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result)
	);

`ifndef NO_ASSERTIONS
	// queue never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	// queue never read when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// end marker closes the run of its item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.stream_end) |->
		(result.last_in_run && result.out_byte == BYTE_END))
		else $error("end beat not last or not the end code");
`endif

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for the temperature bucket stream encoder
// drives begin and sample items, predicts every stream byte and checks each beat
// depends on tbse_pkg, the three channel interfaces and the encoder top level
`timescale 1ns / 1ps

module testbench import tbse_pkg::*;;

	localparam int          NUM_BKT       = 13;
	localparam int          SETTLE_CYCLES = 16;
	localparam logic [1:0]  REG_UNUSED    = 2'd3;

	typedef struct packed {
		logic        op;
		logic [15:0] count;
		logic [31:0] stamp;
		logic [14:0] temp;
	} log_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ends;
	} stream_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	tbse_item_if   item_ch ();
	tbse_result_if byte_ch ();
	tbse_cfg_if    cfg_ch ();

	temperature_bucket_stream_encoder_unit #(
		.NUM_BUCKETS(NUM_BKT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (byte_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	// encoder copy: thresholds and stream state
	logic signed [14:0] cfg_low  = 15'sd2300;
	logic signed [14:0] cfg_high = 15'sd2450;
	logic signed [14:0] cfg_base = 15'sd2200;
	logic               enc_open     = 1'b0;
	logic [15:0]        enc_left     = '0;
	logic               enc_first    = 1'b0;
	logic               enc_prev_exc = 1'b0;
	logic [3:0]         enc_held     = '0;
	logic               enc_half     = 1'b0;

	log_item_t    pending_items[$];
	stream_beat_t expected_bytes[$];
	log_item_t    offered;
	int           mismatch_count = 0;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;

	// long receiver hold-off
	int   hold_len  = 0;
	int   hold_left = 0;
	logic hold_go   = 1'b0;
	logic hold_seen = 1'b0;

	function automatic stream_beat_t beat_of(logic [7:0] b, logic e);
		stream_beat_t s;
		s.data = b;
		s.last = 1'b0;
		s.ends = e;
		return s;
	endfunction

	// expected bytes for one accepted item
	function automatic void encode_item(log_item_t it);
		stream_beat_t run[$];
		int           t;
		int           d;
		logic         exc;
		logic [3:0]   bkt;
		t = $signed(it.temp);
		if (it.op == OP_BEGIN) begin
			enc_open = 1'b0;
			enc_left = '0;
			enc_first = 1'b0;
			enc_prev_exc = 1'b0;
			enc_held = '0;
			enc_half = 1'b0;
			run.push_back(beat_of(BYTE_HDR0, 1'b0));
			run.push_back(beat_of(BYTE_HDR1, 1'b0));
			run.push_back(beat_of(it.count[7:0], 1'b0));
			run.push_back(beat_of(it.count[15:8], 1'b0));
			run.push_back(beat_of(8'(NUM_BKT), 1'b0));
			if (it.count == 16'd0)
				run.push_back(beat_of(BYTE_END, 1'b1));
			else begin
				enc_open = 1'b1;
				enc_left = it.count;
			end
		end else if (enc_open) begin
			exc = (t < cfg_low) || (t > cfg_high);
			// first sample carries the timestamp, later ones mark excursion changes
			if (!enc_first) begin
				enc_first = 1'b1;
				enc_prev_exc = exc;
				run.push_back(beat_of(BYTE_TS, 1'b0));
				for (int i = 0; i < 4; i++)
					run.push_back(beat_of(it.stamp[8*i +: 8], 1'b0));
			end else if (exc != enc_prev_exc) begin
				if (enc_half) begin
					run.push_back(beat_of({enc_held, 4'h0}, 1'b0));
					enc_held = '0;
					enc_half = 1'b0;
				end
				run.push_back(beat_of(BYTE_EXC, 1'b0));
				enc_prev_exc = exc;
			end
			// bucket, clamped to the top one
			d = t - cfg_base;
			if (d < 0)
				bkt = '0;
			else if (d / BUCKET_WIDTH > NUM_BKT - 1)
				bkt = 4'(NUM_BKT - 1);
			else
				bkt = 4'(d / BUCKET_WIDTH);
			if (!enc_half) begin
				enc_held = bkt;
				enc_half = 1'b1;
			end else begin
				run.push_back(beat_of({enc_held, bkt}, 1'b0));
				enc_held = '0;
				enc_half = 1'b0;
			end
			// closing sample
			enc_left = enc_left - 16'd1;
			if (enc_left == 16'd0) begin
				if (enc_half) begin
					run.push_back(beat_of({enc_held, 4'h0}, 1'b0));
					enc_held = '0;
					enc_half = 1'b0;
				end
				run.push_back(beat_of(BYTE_END, 1'b1));
				enc_open = 1'b0;
				enc_first = 1'b0;
				enc_prev_exc = 1'b0;
			end
		end
		if (run.size() != 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			expected_bytes.push_back(run[i]);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("tb: mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				encode_item(offered);
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_items.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.opcode <= offered.op;
					item_ch.sample_count <= offered.count;
					item_ch.time_ms <= offered.stamp;
					item_ch.temp_centi <= offered.temp;
				end else
					item_ch.valid <= 1'b0;
			end
		end
	end

	// hold-off counter
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_left <= hold_len;
			hold_seen <= hold_go;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// byte monitor
	always @(posedge clk) begin : byte_mon
		stream_beat_t want;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				if (expected_bytes.size() == 0)
					flag_mismatch($sformatf("unexpected beat %02h", byte_ch.out_byte));
				else begin
					want = expected_bytes.pop_front();
					if (byte_ch.out_byte !== want.data)
						flag_mismatch($sformatf("out_byte %02h, want %02h",
							byte_ch.out_byte, want.data));
					if (byte_ch.last_in_run !== want.last)
						flag_mismatch($sformatf("last_in_run %b, want %b on byte %02h",
							byte_ch.last_in_run, want.last, want.data));
					if (byte_ch.stream_end !== want.ends)
						flag_mismatch($sformatf("stream_end %b, want %b on byte %02h",
							byte_ch.stream_end, want.ends, want.data));
				end
			end
			byte_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_begin(input int cnt);
		log_item_t it;
		it.op = OP_BEGIN;
		it.count = cnt[15:0];
		it.stamp = $urandom();
		it.temp = 15'($urandom());
		pending_items.push_back(it);
	endtask

	task automatic push_sample(input int t, input logic [31:0] stamp);
		log_item_t it;
		it.op = OP_SAMPLE;
		it.count = 16'($urandom());
		it.stamp = stamp;
		it.temp = t[14:0];
		pending_items.push_back(it);
	endtask

	// temperatures mostly around the thresholds and the bucket range
	function automatic int pick_temp();
		int r;
		int span;
		r = $urandom_range(99);
		span = int'(cfg_high) - int'(cfg_low);
		if (span < 0)
			span = 0;
		if (r < 40)
			return int'(cfg_low) - 120 + int'($urandom_range(span + 240));
		else if (r < 65)
			return int'(cfg_base) - 60 + int'($urandom_range(720));
		else if (r < 90)
			return -4000 + int'($urandom_range(12500));
		return int'($urandom_range(32767));
	endfunction

	// mostly complete streams, some abandoned ones, empty ones and strays
	task automatic queue_random(input int n);
		int made;
		int r;
		int len;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if (r < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
				push_begin(len);
				repeat (len)
					push_sample(pick_temp(), $urandom());
				made += len + 1;
			end else if (r < 82) begin
				len = $urandom_range(3);
				push_begin($urandom_range(65535));
				repeat (len)
					push_sample(pick_temp(), $urandom());
				made += len + 1;
			end else if (r < 90) begin
				push_begin(0);
				made++;
			end else
				push_sample(pick_temp(), $urandom());
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val[14:0];
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_EXC_LOW:  cfg_low = val[14:0];
			REG_EXC_HIGH: cfg_high = val[14:0];
			REG_BASE:     cfg_base = val[14:0];
			default:      ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || item_ch.valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_BEGIN;
		item_ch.sample_count = '0;
		item_ch.time_ms = '0;
		item_ch.temp_centi = '0;
		byte_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_EXC_LOW;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed run at reset thresholds, no idling
		push_sample(2300, 32'h1234_5678);
		push_begin(0);
		push_begin(65535);
		push_sample(-4000, 32'hFFFF_FFFF);
		push_begin(3);
		push_sample(2200, 32'h8000_0001);
		push_sample(2300, 32'h0);
		push_sample(8500, 32'h0);
		push_begin(4);
		push_sample(2350, 32'hA5A5_5A5A);
		push_sample(2399, 32'h0);
		push_sample(2450, 32'h0);
		push_sample(2451, 32'h0);
		push_begin(2);
		push_sample(-16384, 32'h0);
		push_sample(16383, 32'h0);
		push_begin(1);
		push_sample(2250, 32'h0000_00FF);
		push_sample(2400, 32'h0);
		push_begin(5);
		push_sample(2199, 32'h0102_0304);
		push_sample(2249, 32'h0);
		push_sample(2250, 32'h0);
		push_sample(2899, 32'h0);
		push_sample(2850, 32'h0);
		wait_idle();

		// widest thresholds, no idling
		write_reg(REG_EXC_LOW, -4000);
		write_reg(REG_EXC_HIGH, 8500);
		write_reg(REG_BASE, -4000);
		queue_random(40);
		wait_idle();

		// thresholds out of order, sender idling
		write_reg(REG_EXC_LOW, 8500);
		write_reg(REG_EXC_HIGH, -4000);
		write_reg(REG_BASE, 8500);
		send_idle_pct = 68;
		queue_random(40);
		wait_idle();

		// receiver stalling, with one long hold-off so the input backs up
		write_reg(REG_EXC_LOW, 1000);
		write_reg(REG_EXC_HIGH, 3000);
		write_reg(REG_BASE, 500);
		send_idle_pct = 0;
		recv_stall_pct = 68;
		hold_len <= 400;
		hold_go <= ~hold_go;
		queue_random(40);
		wait_idle();

		// full 15-bit extremes and the unused index, no idling
		write_reg(REG_EXC_LOW, -16384);
		write_reg(REG_EXC_HIGH, 16383);
		write_reg(REG_BASE, 16383);
		write_reg(REG_UNUSED, int'($urandom_range(32767)));
		recv_stall_pct = 0;
		queue_random(15);
		wait_idle();

		// narrow band, both sides idling now and then
		write_reg(REG_EXC_LOW, 2250);
		write_reg(REG_EXC_HIGH, 2700);
		write_reg(REG_BASE, 2000);
		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random(30);
		wait_idle();

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
design/tbse_pkg.sv
design/tbse_item_if.sv
design/tbse_result_if.sv
design/tbse_cfg_if.sv
design/tbse_front.sv
design/tbse_fifo.sv
design/tbse_back.sv
design/temperature_bucket_stream_encoder_unit.sv
bench/testbench.sv
